/* design/bffa_pkg.sv */
// Shared types, codes and helper functions of the bitmap first-free allocator.
package bffa_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic CFG_BYTES = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam int CFG_W         = 14;
    localparam int BYTES_W       = 11;
    localparam int LIMIT_W       = 14;
    localparam int IDX_W         = 13;
    localparam int LANES         = 16;
    localparam int WORD_W        = 128;
    localparam int IDX_FIELD_LIM = 8192;

    localparam logic [BYTES_W-1:0] BYTES_RESET = 11'd1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd614;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] byte_index;
        logic [7:0] byte_value;
    } t_in;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] alloc_index;
        logic [7:0]       read_value;
    } t_out;

    typedef struct packed {
        logic clr_wr;
        logic take;
        logic load_wr;
        logic rd_issue;
        logic scan_start;
        logic scan_step;
        logic alwr;
        logic res_load;
    } t_ctrl;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] kind;
        logic       span_zero;
        logic       decided;
        logic       found_ok;
        logic       out_free;
    } t_stat;

    function automatic logic [2:0] first_clear(input logic [7:0] b);
        logic [2:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--) begin
            if (!b[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

/* design/bitmap_first_free_allocator.sv */
// Top level of the bitmap first-free allocator: controller and datapath.
//
// The block keeps an allocation bitmap of MAP_BYTES bytes in one memory of 128-bit rows
// (16 map bytes per row) and serves load, read and allocate words. After reset a clearing
// pass writes zeros to every row, one row per cycle; no input word is taken during it,
// while configuration writes are. A load or a read passes through an execute state, in
// which the map byte is written or the memory row is read, and a finish state that loads
// the result register. An allocate reads one memory row per cycle from row 0 upward and
// stops at the first row that holds a clear bit in the bytes in use, or at the last row in
// use; the single memory read port sets this row-by-row pace. An output register holds a
// finished result, so the next input word is taken while that result waits to be taken.
module bitmap_first_free_allocator #(
    parameter int MAP_BYTES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  bffa_pkg::t_in               i_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output bffa_pkg::t_out              o_res,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [bffa_pkg::CFG_W-1:0]  i_cfg_data
);

    bffa_pkg::t_ctrl cmd;
    bffa_pkg::t_stat stat;

    bffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bffa_dp #(
        .MAP_BYTES (MAP_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res)
    );

endmodule

/* design/bffa_ctrl.sv */
// Controller state machine of the bitmap first-free allocator.
module bffa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  bffa_pkg::t_stat  i_stat,
    output bffa_pkg::t_ctrl  o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_ALWR  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_stat.kind)
                    bffa_pkg::KIND_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                        n_state       = ST_FIN;
                    end
                    bffa_pkg::KIND_ALLOC: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = i_stat.span_zero ? ST_FIN : ST_SCAN;
                    end
                    bffa_pkg::KIND_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = ST_FIN;
                    end
                    default: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.decided) begin
                    n_state = i_stat.found_ok ? ST_ALWR : ST_FIN;
                end
            end
            ST_ALWR: begin
                o_cmd.alwr = 1'b1;
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

/* design/bffa_dp.sv */
// Datapath of the bitmap first-free allocator: map memory, scan logic and result register.
module bffa_dp #(
    parameter int MAP_BYTES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bffa_pkg::t_ctrl               i_cmd,
    output bffa_pkg::t_stat               o_stat,
    input  bffa_pkg::t_in                 i_item,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bffa_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output bffa_pkg::t_out                o_res
);

    localparam int LANES = bffa_pkg::LANES;
    localparam int ROWS  = (MAP_BYTES + LANES - 1) / LANES;
    localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W = 18;
    localparam int HIT_W = RA_W + 7;
    localparam int CMP_W = ((HIT_W > bffa_pkg::LIMIT_W) ? HIT_W : bffa_pkg::LIMIT_W) + 1;

    logic [bffa_pkg::BYTES_W-1:0] r_cfg_bytes;
    logic [bffa_pkg::LIMIT_W-1:0] r_cfg_limit;
    bffa_pkg::t_in                r_item;
    bffa_pkg::t_word              mem [ROWS];
    bffa_pkg::t_word              r_rdata;
    logic [RA_W-1:0]              r_clr_row;
    logic [RA_W-1:0]              r_rd_row;
    logic                         r_rd_done;
    logic [RA_W-1:0]              r_ev_row;
    logic                         r_ev_vld;
    logic                         r_res_status;
    logic [bffa_pkg::IDX_W-1:0]   r_res_idx;
    logic [RA_W-1:0]              r_upd_row;
    bffa_pkg::t_word              r_upd_word;
    logic                         r_out_valid;
    bffa_pkg::t_out               r_out;
    bffa_pkg::t_out               n_out;

    logic [POS_W-1:0]     span;
    logic                 span_zero;
    logic [RA_W-1:0]      last_row;
    logic [RA_W-1:0]      item_row;
    logic [3:0]           item_lane;
    logic                 in_range;
    logic [LANES-1:0]     byte_ok;
    logic [2:0]           lane_bit [LANES];
    logic [3:0]           hit_lane;
    logic [2:0]           hit_bit;
    logic [HIT_W-1:0]     hit_idx;
    logic                 any_zero;
    logic                 found_ok;
    logic                 decided;
    logic                 scan_re;
    logic                 mem_we;
    logic [RA_W-1:0]      mem_wa;
    logic [LANES-1:0]     mem_be;
    bffa_pkg::t_word      mem_wd;
    logic                 mem_re;
    logic [RA_W-1:0]      mem_ra;
    logic                 out_free;

    // Span of the search, saturated at the map size.
    always_comb begin
        if (POS_W'(r_cfg_bytes) < POS_W'(MAP_BYTES)) begin
            span = POS_W'(r_cfg_bytes);
        end else begin
            span = POS_W'(MAP_BYTES);
        end
    end

    assign span_zero = (span == '0);
    assign last_row  = RA_W'((span - POS_W'(1)) >> 4);
    assign item_row  = RA_W'(r_item.byte_index >> 4);
    assign item_lane = r_item.byte_index[3:0];
    assign in_range  = POS_W'(r_item.byte_index) < POS_W'(MAP_BYTES);

    // Evaluation of one registered memory word during a scan.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            byte_ok[l]  = (POS_W'({r_ev_row, 4'(l)}) < span)
                          && (r_rdata[8*l +: 8] != 8'hFF);
            lane_bit[l] = bffa_pkg::first_clear(r_rdata[8*l +: 8]);
        end
        hit_lane = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (byte_ok[l]) begin
                hit_lane = 4'(l);
            end
        end
    end

    assign any_zero = |byte_ok;
    assign hit_bit  = lane_bit[hit_lane];
    assign hit_idx  = {r_ev_row, hit_lane, hit_bit};
    assign found_ok = any_zero
                      && (CMP_W'(hit_idx) < CMP_W'(r_cfg_limit))
                      && (CMP_W'(hit_idx) < CMP_W'(bffa_pkg::IDX_FIELD_LIM));
    assign decided  = r_ev_vld && (any_zero || (r_ev_row == last_row));
    assign scan_re  = i_cmd.scan_step && !r_rd_done;

    // Memory port selection.
    always_comb begin
        mem_we = i_cmd.clr_wr || (i_cmd.load_wr && in_range) || i_cmd.alwr;
        mem_be = '1;
        mem_wd = r_upd_word;
        mem_wa = r_upd_row;
        if (i_cmd.clr_wr) begin
            mem_wa = r_clr_row;
            mem_wd = '0;
        end else if (i_cmd.load_wr) begin
            mem_wa = item_row;
            mem_be = LANES'(1) << item_lane;
            mem_wd = {LANES{r_item.byte_value}};
        end
        mem_re = (i_cmd.rd_issue && in_range) || scan_re;
        mem_ra = i_cmd.rd_issue ? item_row : r_rd_row;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int k = 0; k < LANES; k++) begin
                if (mem_be[k]) begin
                    mem[mem_wa][8*k +: 8] <= mem_wd[8*k +: 8];
                end
            end
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bytes <= bffa_pkg::BYTES_RESET;
            r_cfg_limit <= bffa_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bffa_pkg::CFG_BYTES: r_cfg_bytes <= i_cfg_data[bffa_pkg::BYTES_W-1:0];
                bffa_pkg::CFG_LIMIT: r_cfg_limit <= i_cfg_data[bffa_pkg::LIMIT_W-1:0];
                default: begin
                    r_cfg_bytes <= r_cfg_bytes;
                end
            endcase
        end
    end

    // Scan and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
            r_rd_row  <= '0;
            r_rd_done <= 1'b0;
            r_ev_vld  <= 1'b0;
        end else begin
            if (i_cmd.clr_wr && (r_clr_row != RA_W'(ROWS - 1))) begin
                r_clr_row <= r_clr_row + RA_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_rd_row  <= '0;
                r_rd_done <= 1'b0;
            end else if (scan_re) begin
                if (r_rd_row == last_row) begin
                    r_rd_done <= 1'b1;
                end else begin
                    r_rd_row <= r_rd_row + RA_W'(1);
                end
            end
            r_ev_vld <= scan_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_item;
        end
        if (scan_re) begin
            r_ev_row <= r_rd_row;
        end
        if (i_cmd.scan_start) begin
            r_res_status <= 1'b1;
            r_res_idx    <= '0;
        end else if (i_cmd.scan_step && decided) begin
            r_res_status <= !found_ok;
            r_res_idx    <= found_ok ? bffa_pkg::IDX_W'(hit_idx) : '0;
            r_upd_row    <= r_ev_row;
            r_upd_word   <= r_rdata | (bffa_pkg::t_word'(1) << {hit_lane, hit_bit});
        end
    end

    // Result register.
    always_comb begin
        n_out = '0;
        case (r_item.kind)
            bffa_pkg::KIND_ALLOC: begin
                n_out.status      = r_res_status;
                n_out.alloc_index = r_res_idx;
            end
            bffa_pkg::KIND_READ: begin
                if (in_range) begin
                    n_out.read_value = r_rdata[8*item_lane +: 8];
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    assign o_stat.clr_done  = (r_clr_row == RA_W'(ROWS - 1));
    assign o_stat.kind      = r_item.kind;
    assign o_stat.span_zero = span_zero;
    assign o_stat.decided   = decided;
    assign o_stat.found_ok  = found_ok;
    assign o_stat.out_free  = out_free;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_wr, i_cmd.load_wr, i_cmd.alwr}))
        else $error("Two sources write the map memory in one cycle.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_out_valid || !i_stall))
        else $error("A waiting result word is overwritten.");

    a_grant_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_load && (r_item.kind == bffa_pkg::KIND_ALLOC) && !r_res_status)
        |-> (CMP_W'(r_res_idx) < CMP_W'(r_cfg_limit)))
        else $error("A granted index is not below the index limit.");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_re |-> (r_rd_row <= last_row))
        else $error("The scan reads beyond the rows in use.");

    a_full_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_load && n_out.status) |-> (r_item.kind == bffa_pkg::KIND_ALLOC))
        else $error("A full status is reported for an item that is no allocate.");

endmodule

/* test/bffa_outcome_checker.sv */
// Watches the allocator's channels, predicts every result word and compares it field by field.
module bffa_outcome_checker
    import bffa_pkg::*;
#(
    parameter int MAP_BYTES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in              i_in_word,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out             i_out_word,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    logic [7:0]         usage_map [MAP_BYTES];
    logic [BYTES_W-1:0] span_cfg = BYTES_RESET;
    logic [LIMIT_W-1:0] limit_cfg = LIMIT_RESET;
    t_out               pending_outcomes [$];
    t_out               oldest;
    int                 fails = 0;

    // Applies one word to the local copy of the map and returns the word it must produce.
    function automatic t_out apply_word(input t_in w);
        t_out r;
        int   span;
        int   found;
        r = '0;
        case (w.kind)
            KIND_LOAD: begin
                if (w.byte_index < MAP_BYTES) begin
                    usage_map[w.byte_index] = w.byte_value;
                end
            end
            KIND_ALLOC: begin
                span = (int'(span_cfg) > MAP_BYTES) ? MAP_BYTES : int'(span_cfg);
                found = -1;
                for (int b = 0; b < span && found < 0; b++) begin
                    for (int k = 0; k < 8 && found < 0; k++) begin
                        if (!usage_map[b][k]) begin
                            found = b * 8 + k;
                        end
                    end
                end
                if (found >= 0 && found < int'(limit_cfg) && found < IDX_FIELD_LIM) begin
                    usage_map[found >> 3][found & 7] = 1'b1;
                    r.alloc_index = IDX_W'(found);
                end else begin
                    r.status = 1'b1;
                end
            end
            KIND_READ: begin
                if (w.byte_index < MAP_BYTES) begin
                    r.read_value = usage_map[w.byte_index];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (usage_map[i]) usage_map[i] = '0;
            span_cfg = BYTES_RESET;
            limit_cfg = LIMIT_RESET;
            pending_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BYTES) begin
                    span_cfg = i_cfg_data[BYTES_W-1:0];
                end else begin
                    limit_cfg = i_cfg_data[LIMIT_W-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_outcomes.size() == 0) begin
                    fails++;
                    $error("Result word %p arrived with no word outstanding.", i_out_word);
                end else begin
                    oldest = pending_outcomes.pop_front();
                    if (i_out_word.status !== oldest.status) begin
                        fails++;
                        $error("status: expected %0d, got %0d", oldest.status,
                               i_out_word.status);
                    end
                    if (i_out_word.alloc_index !== oldest.alloc_index) begin
                        fails++;
                        $error("alloc_index: expected %0d, got %0d", oldest.alloc_index,
                               i_out_word.alloc_index);
                    end
                    if (i_out_word.read_value !== oldest.read_value) begin
                        fails++;
                        $error("read_value: expected 0x%02h, got 0x%02h", oldest.read_value,
                               i_out_word.read_value);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_outcomes.push_back(apply_word(i_in_word));
            end
        end
        o_pending <= pending_outcomes.size();
        o_fail_count <= fails;
    end

endmodule

/* test/tb_top.sv */
// Testbench top for the bitmap first-free allocator: clock, reset, stimulus and verdict.
module tb_top;
    import bffa_pkg::*;

    localparam int MAP_BYTES = 1024;
    localparam int PHASE_WORDS = 310;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    t_in              i_item = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    t_out             o_res;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = CFG_BYTES;
    logic [CFG_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent = 0;
    int allocs_sent = 0;
    int settings_used = 0;
    int phase_end;
    int run_end;
    int fill_end;

    bitmap_first_free_allocator #(.MAP_BYTES(MAP_BYTES)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (o_res),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    bffa_outcome_checker #(.MAP_BYTES(MAP_BYTES)) outcome_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_word   (i_item),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_word  (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_word(input logic [1:0] kind, input logic [9:0] pos,
                             input logic [7:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= {kind, pos, val};
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        if (kind == KIND_ALLOC) begin
            allocs_sent++;
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] bytes_v, input logic [CFG_W-1:0] limit_v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_BYTES;
        i_cfg_data <= bytes_v;
        @(posedge i_clk);
        i_cfg_idx <= CFG_LIMIT;
        i_cfg_data <= limit_v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_config();
        logic [CFG_W-1:0] b;
        logic [CFG_W-1:0] l;
        case ($urandom_range(9))
            0: b = '0;
            1: b = 14'd1;
            2: b = 14'd2047;
            3: b = 14'd1024;
            4: b = 14'($urandom_range(1025, 2047));
            5, 6: b = 14'($urandom_range(1, 1024));
            default: b = 14'($urandom_range(1, 96));
        endcase
        case ($urandom_range(9))
            0: l = '0;
            1: l = 14'd1;
            2: l = 14'd16383;
            3: l = 14'd8192;
            4: l = 14'd614;
            5: l = 14'($urandom_range(8193, 16383));
            default: l = 14'($urandom_range(2, 700));
        endcase
        set_config(b, l);
    endtask

    // Positions in the low part of the map, where allocations land.
    function automatic logic [9:0] low_pos();
        return 10'($urandom_range(0, 90));
    endfunction

    task automatic random_sequence();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 55) begin
            n = $urandom_range(0, 3);
            repeat (n) send_word(KIND_LOAD, low_pos(),
                                 $urandom_range(1) ? 8'hFF : 8'($urandom));
            n = $urandom_range(1, 8);
            repeat (n) send_word(KIND_ALLOC, 10'($urandom), 8'($urandom));
            send_word(KIND_READ, low_pos(), 8'($urandom));
        end else if (pick < 68) begin
            n = $urandom_range(1, 4);
            repeat (n) send_word(KIND_LOAD, low_pos(),
                                 $urandom_range(1) ? 8'h00 : 8'($urandom));
        end else if (pick < 84) begin
            send_word(KIND_READ, 10'($urandom), 8'($urandom));
        end else if (pick < 93) begin
            send_word(KIND_LOAD, 10'($urandom), 8'($urandom));
        end else begin
            send_word(KIND_SPARE, 10'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words on a two-byte map.
        set_config(14'd2, 14'd8192);
        send_word(KIND_ALLOC, 10'd0, 8'h00);
        send_word(KIND_LOAD, 10'd0, 8'hFF);
        send_word(KIND_ALLOC, 10'd1023, 8'hFF);
        send_word(KIND_LOAD, 10'd1, 8'hFF);
        send_word(KIND_ALLOC, 10'd0, 8'h00);
        send_word(KIND_READ, 10'd0, 8'h00);
        send_word(KIND_READ, 10'd1023, 8'hFF);
        send_word(KIND_LOAD, 10'd1023, 8'hA5);
        send_word(KIND_READ, 10'd1023, 8'h00);
        send_word(KIND_LOAD, 10'd0, 8'h00);
        send_word(KIND_READ, 10'd0, 8'hFF);
        send_word(KIND_SPARE, 10'd1023, 8'hFF);
        wait_drained();
        set_config(14'd0, 14'd8192);
        send_word(KIND_ALLOC, 10'd0, 8'h00);
        wait_drained();
        set_config(14'd2047, 14'd0);
        send_word(KIND_ALLOC, 10'd0, 8'h00);
        wait_drained();
        set_config(14'd2047, 14'd3);
        repeat (4) send_word(KIND_ALLOC, 10'($urandom), 8'($urandom));
        send_word(KIND_READ, 10'd0, 8'h00);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 85 : 0;
            recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 11 : 0;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                wait_drained();
                random_config();
                run_end = words_sent + $urandom_range(60, 140);
                while (words_sent < run_end && words_sent < phase_end) begin
                    random_sequence();
                end
            end
        end

        // Fill the lower half of the map so that allocations reach the top index bit.
        wait_drained();
        set_config(14'd1024, 14'd8192);
        fill_end = $urandom_range(511, 530);
        for (int i = 0; i <= fill_end; i++) begin
            send_word(KIND_LOAD, 10'(i), 8'hFF);
        end
        send_word(KIND_LOAD, 10'(fill_end + 1), 8'($urandom_range(0, 254)));
        repeat (6) send_word(KIND_ALLOC, 10'($urandom), 8'($urandom));
        send_word(KIND_READ, 10'(fill_end + 1), 8'($urandom));

        wait_drained();
        repeat (80) @(posedge i_clk);
        $display("Ran %0d words, %0d of them allocates, over %0d register settings,",
                 words_sent, allocs_sent, settings_used);
        $display("with sender and receiver stalls swapped, then none, and a %0d-byte full map.",
                 fill_end + 1);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* bitmap_first_free_allocator.f */
design/bffa_pkg.sv
design/bffa_ctrl.sv
design/bffa_dp.sv
design/bitmap_first_free_allocator.sv
test/bffa_outcome_checker.sv
test/tb_top.sv
